// ===== design/lfa_pkg.sv =====
// Shared constants and request codes for the lowest-free ID allocator.
// No dependencies.
`timescale 1ns / 1ps

package lfa_pkg;

   localparam int HOST_BITS_DEFAULT = 8;
   localparam int HOST_ID_WIDTH     = 8;
   localparam int RESULT_ID_WIDTH   = 8;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_FIND    = 2'd1,
      REQ_CHECK   = 2'd2,
      REQ_RELEASE = 2'd3
   } req_kind_type;

endpackage

// ===== design/lfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lfa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 511
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lowest_free_id_allocator.sv =====
// Top level of the lowest-free host-ID allocator: control sequencer around the flag tree.
// Depends on lfa_pkg and lfa_ram.
`timescale 1ns / 1ps

// The pool of 2^HOST_BITS IDs is kept as a heap-ordered binary tree of full flags in one
// RAM of 2^(HOST_BITS+1)-1 one-bit entries, visited one node per cycle. After reset the
// block sweeps the RAM to zero, one entry a cycle, and holds req_ready low meanwhile.
// One word is worked on at a time. Check reads the leaf; find reads the root and, if the pool
// is not full, walks down to the lowest free leaf; release clears the leaf and every node up
// to the root; allocate sets the leaf and then each parent as far as fullness climbs the
// tree. The single RAM read port sets the pace of one tree level per cycle. req_ready rises
// as the result is registered, even if that result is not yet taken.

module lowest_free_id_allocator #(
   parameter int HOST_BITS = lfa_pkg::HOST_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic [lfa_pkg::HOST_ID_WIDTH-1:0]   req_host_id,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lfa_pkg::RESULT_ID_WIDTH-1:0] rsp_result_id,
   output logic                                rsp_found,
   output logic                                rsp_id_was_free
);

   localparam int ID_W       = HOST_BITS;
   localparam int NW         = HOST_BITS + 1;
   localparam int NODE_COUNT = (2 << HOST_BITS) - 1;
   localparam int LVL_W      = $clog2(HOST_BITS);
   localparam int HW         = lfa_pkg::HOST_ID_WIDTH;
   localparam int RW         = lfa_pkg::RESULT_ID_WIDTH;

   localparam logic [NW-1:0]    LEAF_BASE = NW'((1 << HOST_BITS) - 1);
   localparam logic [NW-1:0]    LAST_NODE = NW'(NODE_COUNT - 1);
   localparam logic [LVL_W-1:0] LAST_LVL  = LVL_W'(HOST_BITS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIRST,
      ST_FIND,
      ST_ALLOC,
      ST_REL,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   lfa_pkg::req_kind_type kind_ff, kind_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [NW-1:0]         node_ff, node_in;
   logic [LVL_W-1:0]      lvl_ff, lvl_in;
   logic [NW-1:0]         clr_ff, clr_in;
   logic                  found_ff, found_in;
   logic                  free_ff, free_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]         rsp_id_ff, rsp_id_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic                  rsp_free_ff, rsp_free_in;

   logic                  rd_en;
   logic [NW-1:0]         rd_addr;
   logic                  rd_data;
   logic                  wr_en;
   logic [NW-1:0]         wr_addr;
   logic                  wr_data;

   logic [ID_W+HW-1:0]    host_ext;
   logic [ID_W-1:0]       req_id;
   logic [ID_W+RW-1:0]    id_ext;
   logic [NW-1:0]         leaf;
   logic [NW-1:0]         parent;
   logic [NW-1:0]         left;
   logic [NW-1:0]         child;

   function automatic logic [NW-1:0] sibling_of(input logic [NW-1:0] n);
      return n[0] ? n + NW'(1) : n - NW'(1);
   endfunction

   assign host_ext = {{ID_W{1'b0}}, req_host_id};
   assign req_id   = host_ext[ID_W-1:0];
   assign id_ext   = {{RW{1'b0}}, id_ff};
   assign leaf     = LEAF_BASE + {1'b0, id_ff};
   assign parent   = (node_ff - NW'(1)) >> 1;
   assign left     = {node_ff[NW-2:0], 1'b1};
   assign child    = rd_data ? left + NW'(1) : left;

   lfa_ram #(
      .WIDTH(1),
      .DEPTH(NODE_COUNT)
   ) u_flags (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      node_in      = node_ff;
      lvl_in       = lvl_ff;
      clr_in       = clr_ff;
      found_in     = found_ff;
      free_in      = free_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_found_in = rsp_found_ff;
      rsp_free_in  = rsp_free_ff;
      rd_en        = 1'b0;
      rd_addr      = node_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + NW'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = lfa_pkg::req_kind_type'(req_type);
               id_in    = req_id;
               found_in = 1'b0;
               free_in  = 1'b0;
               rd_en    = 1'b1;
               rd_addr  = (req_type == lfa_pkg::REQ_FIND) ? '0 : LEAF_BASE + {1'b0, req_id};
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            unique case (kind_ff)
               lfa_pkg::REQ_FIND: begin
                  if (rd_data) begin
                     id_in    = '0;
                     state_in = ST_DONE;
                  end else begin
                     node_in  = '0;
                     lvl_in   = '0;
                     rd_en    = 1'b1;
                     rd_addr  = NW'(1);
                     state_in = ST_FIND;
                  end
               end
               lfa_pkg::REQ_CHECK: begin
                  free_in  = !rd_data;
                  state_in = ST_DONE;
               end
               lfa_pkg::REQ_ALLOC: begin
                  free_in  = !rd_data;
                  wr_en    = 1'b1;
                  wr_addr  = leaf;
                  wr_data  = 1'b1;
                  node_in  = leaf;
                  rd_en    = 1'b1;
                  rd_addr  = sibling_of(leaf);
                  state_in = ST_ALLOC;
               end
               lfa_pkg::REQ_RELEASE: begin
                  free_in  = !rd_data;
                  wr_en    = 1'b1;
                  wr_addr  = leaf;
                  wr_data  = 1'b0;
                  node_in  = leaf;
                  state_in = ST_REL;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_FIND: begin
            id_in   = {id_ff[ID_W-2:0], rd_data};
            node_in = child;
            lvl_in  = lvl_ff + LVL_W'(1);
            if (lvl_ff == LAST_LVL) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = {child[NW-2:0], 1'b1};
            end
         end
         ST_ALLOC: begin
            if (rd_data) begin
               wr_en   = 1'b1;
               wr_addr = parent;
               wr_data = 1'b1;
               node_in = parent;
               if (parent == '0) begin
                  state_in = ST_DONE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = sibling_of(parent);
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_REL: begin
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = 1'b0;
            node_in = parent;
            if (parent == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ext[RW-1:0];
               rsp_found_in = found_ff;
               rsp_free_in  = free_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      id_ff        <= id_in;
      node_ff      <= node_in;
      lvl_ff       <= lvl_in;
      found_ff     <= found_in;
      free_ff      <= free_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_found_ff <= rsp_found_in;
      rsp_free_ff  <= rsp_free_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_id   = rsp_id_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_id_was_free = rsp_free_ff;

endmodule
